// ----- rtl/ihex_pkg.sv -----
package ihex_pkg;

   localparam int MAX_RECORD_BYTES_DEF = 32;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_D0    = 8'h30;
   localparam logic [7:0] CHAR_D9    = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF_HEX = 8'h66;

   localparam logic [7:0] REC_DATA = 8'h00;
   localparam logic [7:0] REC_EOF  = 8'h01;
   localparam logic [7:0] REC_ESA  = 8'h02;
   localparam logic [7:0] REC_ELA  = 8'h04;

   typedef enum logic [2:0] {
      KIND_DATA     = 3'd0,
      KIND_DONE     = 3'd1,
      KIND_EOF      = 3'd2,
      KIND_BASE     = 3'd3,
      KIND_IGNORED  = 3'd4,
      KIND_FORMAT   = 3'd5,
      KIND_CHECKSUM = 3'd6,
      KIND_TOO_LONG = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      RUN_ACTIVE,
      RUN_FINISHED,
      RUN_ABORTED
   } run_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_READ,
      ST_DATA
   } ctrl_state_type;

   typedef struct packed {
      logic take;
      logic rd_issue;
      logic data_load;
      logic emit_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic ev_single;
      logic ev_drain;
      logic idx_last;
      logic out_free;
   } dp_status_type;

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] diff;
      diff = 8'h00;
      if (c >= CHAR_D0 && c <= CHAR_D9) begin
         diff = c - CHAR_D0;
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         diff = c - CHAR_UA + 8'd10;
      end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
         diff = c - CHAR_LA + 8'd10;
      end
      return diff[3:0];
   endfunction

   function automatic logic is_eol(input logic [7:0] c);
      return (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
             (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
   endfunction

endpackage

// ----- rtl/ihex_req_if.sv -----
interface ihex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

// ----- rtl/ihex_rsp_if.sv -----
interface ihex_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] address;
   logic [7:0]  data;
   logic        last;

   modport source (output valid, output kind, output address, output data, output last,
                   input ready);
   modport sink (input valid, input kind, input address, input data, input last,
                 output ready);
endinterface

// ----- rtl/ihex_ram.sv -----
module ihex_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ihex_ctrl.sv -----
module ihex_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  ihex_pkg::dp_status_type status,
   output ihex_pkg::ctrl_cmd_type  cmd,
   output ihex_pkg::ctrl_state_type state
);

   ihex_pkg::ctrl_state_type state_ff;
   ihex_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ihex_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ihex_pkg::ST_IDLE: begin
            cmd.take = 1'b1;
            if (status.ev_drain) begin
               state_in = ihex_pkg::ST_READ;
            end else if (status.ev_single) begin
               state_in = ihex_pkg::ST_EMIT;
            end
         end
         ihex_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               state_in      = ihex_pkg::ST_IDLE;
            end
         end
         ihex_pkg::ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ihex_pkg::ST_DATA;
         end
         ihex_pkg::ST_DATA: begin
            if (status.out_free) begin
               cmd.data_load = 1'b1;
               state_in = status.idx_last ? ihex_pkg::ST_EMIT : ihex_pkg::ST_READ;
            end
         end
         default: begin
            state_in = ihex_pkg::ST_IDLE;
         end
      endcase
   end

   assign state = state_ff;

endmodule

// ----- rtl/ihex_dp.sv -----
module ihex_dp #(
   parameter int MAX_RECORD_BYTES = ihex_pkg::MAX_RECORD_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ihex_pkg::ctrl_cmd_type  cmd,
   output ihex_pkg::dp_status_type status,
   input  logic                    in_valid,
   input  logic [7:0]              in_ch,
   input  logic                    out_ready,
   output logic                    out_valid,
   output logic [2:0]              out_kind,
   output logic [31:0]             out_address,
   output logic [7:0]              out_data,
   output logic                    out_last
);

   localparam int PW = $clog2(2 * MAX_RECORD_BYTES + 12);
   localparam int BW = PW - 1;
   localparam int CW = (BW > 8) ? BW : 8;
   localparam int AW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;

   logic [PW-1:0]      pos_ff, pos_in;
   logic               skip_ff, skip_in;
   logic [3:0]         hi_ff, hi_in;
   logic [7:0]         len_ff, len_in;
   logic [15:0]        off_ff, off_in;
   logic [7:0]         rkind_ff, rkind_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         d0_ff, d0_in;
   logic [7:0]         d1_ff, d1_in;
   logic [31:0]        base_ff, base_in;
   ihex_pkg::run_type  run_ff, run_in;
   ihex_pkg::kind_type stg_kind_ff, stg_kind_in;
   logic [31:0]        stg_addr_ff, stg_addr_in;
   logic [7:0]         stg_data_ff, stg_data_in;
   logic [31:0]        drain_addr_ff, drain_addr_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               out_valid_ff, out_valid_in;
   ihex_pkg::kind_type out_kind_ff, out_kind_in;
   logic [31:0]        out_addr_ff, out_addr_in;
   logic [7:0]         out_data_ff, out_data_in;
   logic               out_last_ff, out_last_in;

   logic               accept;
   logic [3:0]         nib;
   logic [7:0]         byte_v;
   logic [7:0]         sum_nx;
   logic [BW-1:0]      bidx;
   logic [BW-1:0]      didx;
   logic [31:0]        new_base;
   logic               ev_single;
   logic               ev_drain;
   logic               wr_en;
   logic [7:0]         rd_data;

   assign accept   = cmd.take && in_valid;
   assign nib      = ihex_pkg::nibble_of(in_ch);
   assign byte_v   = {hi_ff, nib};
   assign sum_nx   = sum_ff + byte_v;
   assign bidx     = pos_ff[PW-1:1] - BW'(1);
   assign didx     = bidx - BW'(4);
   assign new_base = (rkind_ff == ihex_pkg::REC_ELA) ? {d0_ff, d1_ff, 16'h0000}
                                                     : {12'h000, d0_ff, d1_ff, 4'h0};

   always_comb begin
      pos_in        = pos_ff;
      skip_in       = skip_ff;
      hi_in         = hi_ff;
      len_in        = len_ff;
      off_in        = off_ff;
      rkind_in      = rkind_ff;
      sum_in        = sum_ff;
      d0_in         = d0_ff;
      d1_in         = d1_ff;
      base_in       = base_ff;
      run_in        = run_ff;
      stg_kind_in   = stg_kind_ff;
      stg_addr_in   = stg_addr_ff;
      stg_data_in   = stg_data_ff;
      drain_addr_in = drain_addr_ff;
      idx_in        = idx_ff;
      ev_single     = 1'b0;
      ev_drain      = 1'b0;
      wr_en         = 1'b0;

      if (accept && run_ff == ihex_pkg::RUN_ACTIVE) begin
         if (skip_ff) begin
            if (ihex_pkg::is_eol(in_ch)) begin
               skip_in = 1'b0;
               pos_in  = '0;
            end
         end else if (pos_ff == '0) begin
            if (in_ch == ihex_pkg::CHAR_COLON) begin
               pos_in   = PW'(1);
               sum_in   = '0;
               len_in   = '0;
               off_in   = '0;
               rkind_in = '0;
            end else if (!ihex_pkg::is_blank(in_ch)) begin
               run_in      = ihex_pkg::RUN_ABORTED;
               ev_single   = 1'b1;
               stg_kind_in = ihex_pkg::KIND_FORMAT;
               stg_addr_in = '0;
               stg_data_in = '0;
            end
         end else if (ihex_pkg::is_eol(in_ch)) begin
            run_in      = ihex_pkg::RUN_ABORTED;
            ev_single   = 1'b1;
            stg_kind_in = ihex_pkg::KIND_FORMAT;
            stg_addr_in = '0;
            stg_data_in = '0;
         end else begin
            pos_in = pos_ff + PW'(1);
            if (pos_ff[0]) begin
               hi_in = nib;
            end else begin
               sum_in = sum_nx;
               if (bidx == BW'(0)) begin
                  len_in = byte_v;
                  if (byte_v > 8'(MAX_RECORD_BYTES)) begin
                     run_in      = ihex_pkg::RUN_ABORTED;
                     ev_single   = 1'b1;
                     stg_kind_in = ihex_pkg::KIND_TOO_LONG;
                     stg_addr_in = '0;
                     stg_data_in = '0;
                  end
               end else if (bidx == BW'(1)) begin
                  off_in[15:8] = byte_v;
               end else if (bidx == BW'(2)) begin
                  off_in[7:0] = byte_v;
               end else if (bidx == BW'(3)) begin
                  rkind_in = byte_v;
               end else if (CW'(didx) < CW'(len_ff)) begin
                  wr_en = 1'b1;
                  if (didx == BW'(0)) begin
                     d0_in = byte_v;
                  end
                  if (didx == BW'(1)) begin
                     d1_in = byte_v;
                  end
               end else if (sum_nx != 8'h00) begin
                  run_in      = ihex_pkg::RUN_ABORTED;
                  ev_single   = 1'b1;
                  stg_kind_in = ihex_pkg::KIND_CHECKSUM;
                  stg_addr_in = '0;
                  stg_data_in = '0;
               end else begin
                  skip_in     = 1'b1;
                  stg_addr_in = '0;
                  stg_data_in = '0;
                  case (rkind_ff) inside
                     ihex_pkg::REC_DATA: begin
                        stg_kind_in   = ihex_pkg::KIND_DONE;
                        ev_drain      = (len_ff != 8'h00);
                        ev_single     = (len_ff == 8'h00);
                        drain_addr_in = base_ff + 32'(off_ff);
                        idx_in        = '0;
                     end
                     ihex_pkg::REC_EOF: begin
                        run_in      = ihex_pkg::RUN_FINISHED;
                        ev_single   = 1'b1;
                        stg_kind_in = ihex_pkg::KIND_EOF;
                     end
                     ihex_pkg::REC_ELA, ihex_pkg::REC_ESA: begin
                        ev_single = 1'b1;
                        if (len_ff == 8'd2) begin
                           base_in     = new_base;
                           stg_kind_in = ihex_pkg::KIND_BASE;
                           stg_addr_in = new_base;
                        end else begin
                           stg_kind_in = ihex_pkg::KIND_IGNORED;
                           stg_data_in = rkind_ff;
                        end
                     end
                     default: begin
                        ev_single   = 1'b1;
                        stg_kind_in = ihex_pkg::KIND_IGNORED;
                        stg_data_in = rkind_ff;
                     end
                  endcase
               end
            end
         end
      end

      if (cmd.data_load) begin
         idx_in        = idx_ff + AW'(1);
         drain_addr_in = drain_addr_ff + 32'd1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_addr_in  = out_addr_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (cmd.data_load) begin
         out_valid_in = 1'b1;
         out_kind_in  = ihex_pkg::KIND_DATA;
         out_addr_in  = drain_addr_ff;
         out_data_in  = rd_data;
         out_last_in  = 1'b0;
      end else if (cmd.emit_load) begin
         out_valid_in = 1'b1;
         out_kind_in  = stg_kind_ff;
         out_addr_in  = stg_addr_ff;
         out_data_in  = stg_data_ff;
         out_last_in  = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         skip_ff      <= 1'b0;
         hi_ff        <= '0;
         len_ff       <= '0;
         off_ff       <= '0;
         rkind_ff     <= '0;
         sum_ff       <= '0;
         base_ff      <= '0;
         run_ff       <= ihex_pkg::RUN_ACTIVE;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         skip_ff      <= skip_in;
         hi_ff        <= hi_in;
         len_ff       <= len_in;
         off_ff       <= off_in;
         rkind_ff     <= rkind_in;
         sum_ff       <= sum_in;
         base_ff      <= base_in;
         run_ff       <= run_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d0_ff         <= d0_in;
      d1_ff         <= d1_in;
      stg_kind_ff   <= stg_kind_in;
      stg_addr_ff   <= stg_addr_in;
      stg_data_ff   <= stg_data_in;
      drain_addr_ff <= drain_addr_in;
      idx_ff        <= idx_in;
      out_kind_ff   <= out_kind_in;
      out_addr_ff   <= out_addr_in;
      out_data_ff   <= out_data_in;
      out_last_ff   <= out_last_in;
   end

   ihex_ram #(
      .WIDTH (8),
      .DEPTH (MAX_RECORD_BYTES)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(didx)),
      .wr_data (byte_v),
      .rd_en   (cmd.rd_issue),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign status.ev_single = ev_single;
   assign status.ev_drain  = ev_drain;
   assign status.idx_last  = (CW'(idx_ff) + CW'(1)) == CW'(len_ff);
   assign status.out_free  = !out_valid_ff || out_ready;

   assign out_valid   = out_valid_ff;
   assign out_kind    = out_kind_ff;
   assign out_address = out_addr_ff;
   assign out_data    = out_data_ff;
   assign out_last    = out_last_ff;

endmodule

// ----- rtl/intel_hex_record_parser.sv -----
// Intel HEX record parser. The req channel takes one ASCII character per beat;
// the rsp channel returns the results a character causes, the final one with
// last set. Whitespace between records and the tail of a line after a good
// record give no result.
// A character is taken when the block is idle. A character that
// causes one result (base set, end of file, ignored record, error) puts it
// in a staging register, then in the output register when that is free, and
// the block is ready again once the result is in the output register. A data
// record drains from the record buffer byte by byte (buffer read, then
// output register load when it is free), followed by the record-done result;
// no character is taken until that result is in the output register.
// The output register holds a result while rsp is stalled, and the block
// accepts the next character as long as the result of the previous one is
// already in that register.
// After an end-of-file record or any error the block still accepts characters
// but gives no further results until reset. Synchronous reset returns the
// block to waiting for a colon with a zero base address; the record buffer
// needs no clearing.
module intel_hex_record_parser #(
   parameter int MAX_RECORD_BYTES = ihex_pkg::MAX_RECORD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ihex_req_if.sink    req_if,
   ihex_rsp_if.source  rsp_if
);

   ihex_pkg::ctrl_cmd_type   cmd;
   ihex_pkg::dp_status_type  status;
   ihex_pkg::ctrl_state_type state;

   ihex_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd),
      .state  (state)
   );

   ihex_dp #(
      .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .in_valid    (req_if.valid),
      .in_ch       (req_if.ch),
      .out_ready   (rsp_if.ready),
      .out_valid   (rsp_if.valid),
      .out_kind    (rsp_if.kind),
      .out_address (rsp_if.address),
      .out_data    (rsp_if.data),
      .out_last    (rsp_if.last)
   );

   assign req_if.ready = cmd.take;

   // Only one of taking a character, reading the buffer or loading a result happens per cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.rd_issue, cmd.data_load, cmd.emit_load}))
      else $error("controller issued overlapping commands");

   // A result never overwrites one that the receiver has not taken.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.data_load || cmd.emit_load) |-> status.out_free)
      else $error("output register overwritten while stalled");

   // A data byte is never flagged as the final result; the record-done result follows it.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.kind == ihex_pkg::KIND_DATA) |-> !rsp_if.last)
      else $error("data byte flagged as the final result");

   // The buffer read data is consumed only in the cycle after a read or while stalled on it.
   assert property (@(posedge clock) disable iff (reset)
      cmd.data_load |-> ($past(cmd.rd_issue) || $past(state == ihex_pkg::ST_DATA)))
      else $error("data loaded without a buffer read");

endmodule
